// ----- rtl/core/spq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants
// Transaction structs, action codes and the cell command for the sorted
// priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DATA_W           = 32;
  localparam int COUNT_OUT_W      = 5;
  localparam int DEFAULT_CAPACITY = 16;

  localparam logic [DATA_W-1:0] EMPTY_MARK = {DATA_W{1'b1}};

  // Action codes; the fourth code is a no-op
  localparam logic [1:0] ACT_INSERT   = 2'd0;
  localparam logic [1:0] ACT_POP      = 2'd1;
  localparam logic [1:0] ACT_CONTAINS = 2'd2;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] value;
  } spq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic                     popped_valid;
    logic                     found;
    logic                     overflow;
    logic signed [DATA_W-1:0] head_value;
    logic signed [DATA_W-1:0] tail_value;
    logic [COUNT_OUT_W-1:0]   entry_count;
  } spq_out_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic                     ins;
    logic                     pop;
    logic signed [DATA_W-1:0] key;
  } spq_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/sorted_priority_queue_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: bounded min-first sorted queue
// Insert, pop-smallest and contains on a chain of CAPACITY cells.
// ----------------------------------------------------------------------------
// On accept, every cell of the chain is updated in parallel and the per-cell
// match bits are captured; in the evaluation state that follows, the match
// bits are folded into the found flag and the result register is loaded.
// A new request is taken once the state is back to idle and the result
// register is empty or draining, so no new transaction is taken before the
// last one is through its evaluation. Head comes from the first cell, tail and
// count from dedicated registers. An insert into a full queue is dropped
// and flagged as overflow.
module sorted_priority_queue_unit #(
  parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                req_valid,
  output logic               req_ready,
  input  wire spq_pkg::spq_in_t req,
  output logic               rsp_valid,
  input  wire                rsp_ready,
  output spq_pkg::spq_out_t  rsp
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic                     accept;
  logic                     full;
  logic                     empty;
  logic                     do_ins;
  logic                     do_pop;
  spq_cmd_t                 cmd;
  logic [CNT_W-1:0]         count;
  logic signed [DATA_W-1:0] tail;
  logic signed [DATA_W-1:0] popped;
  logic                     pvalid;
  logic                     ovf;
  logic [CAPACITY-1:0]      match_q;

  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]      cell_valid;
  logic [CAPACITY-1:0]      cell_gt;
  logic [CAPACITY-1:0]      cell_match;

  // Handshake and decode
  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;
  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign do_ins    = accept && (req.action == ACT_INSERT) && !full;
  assign do_pop    = accept && (req.action == ACT_POP) && !empty;

  assign cmd.ins = do_ins;
  assign cmd.pop = do_pop;
  assign cmd.key = req.value;

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] lv;
    logic signed [DATA_W-1:0] rv;
    logic                     lvalid;
    logic                     lgt;
    logic                     rvalid;

    if (i == 0) begin : g_first
      assign lv     = '0;
      assign lvalid = 1'b1;
      assign lgt    = 1'b0;
    end else begin : g_inner_l
      assign lv     = cell_val[i-1];
      assign lvalid = cell_valid[i-1];
      assign lgt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rv     = '0;
      assign rvalid = 1'b0;
    end else begin : g_inner_r
      assign rv     = cell_val[i+1];
      assign rvalid = cell_valid[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_val    (lv),
      .left_valid  (lvalid),
      .left_gt     (lgt),
      .right_val   (rv),
      .right_valid (rvalid),
      .val         (cell_val[i]),
      .valid       (cell_valid[i]),
      .gt          (cell_gt[i]),
      .match       (cell_match[i])
    );
  end

  // Count and tail tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_ins) begin
      count <= count + 1'b1;
    end else if (do_pop) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_ins && (empty || !(tail > req.value))) begin
      tail <= req.value;
    end
  end

  // Per-transaction flags captured at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      popped  <= do_pop ? cell_val[0] : EMPTY_MARK;
      pvalid  <= do_pop;
      ovf     <= (req.action == ACT_INSERT) && full;
      match_q <= (req.action == ACT_CONTAINS) ? cell_match : '0;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_EVAL;
      S_EVAL:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_EVAL) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      rsp.popped_value <= popped;
      rsp.popped_valid <= pvalid;
      rsp.found        <= |match_q;
      rsp.overflow     <= ovf;
      rsp.head_value   <= empty ? EMPTY_MARK : cell_val[0];
      rsp.tail_value   <= empty ? EMPTY_MARK : tail;
      rsp.entry_count  <= COUNT_OUT_W'(count);
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("cell valid bits disagree with entry count");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_EVAL))
    else $error("result raised without an evaluation cycle");

  for (genvar k = 0; k < CAPACITY - 1; k++) begin : g_order_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      cell_valid[k+1] |-> (cell_valid[k] && !(cell_val[k] > cell_val[k+1])))
      else $error("chain out of order");
  end

endmodule
`default_nettype wire

// ----- rtl/core/spq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one value and its valid bit; shifts right on insert, left on pop,
// and reports its compare and match results against the broadcast key.
// ----------------------------------------------------------------------------
module spq_cell (
  input  wire                              clk,
  input  wire                              rst,
  input  wire spq_pkg::spq_cmd_t           cmd,
  input  wire signed [spq_pkg::DATA_W-1:0] left_val,
  input  wire                              left_valid,
  input  wire                              left_gt,
  input  wire signed [spq_pkg::DATA_W-1:0] right_val,
  input  wire                              right_valid,
  output logic signed [spq_pkg::DATA_W-1:0] val,
  output logic                             valid,
  output logic                             gt,
  output logic                             match
);
  import spq_pkg::*;

  // Empty slots count as greater, so new values land after equal entries
  assign gt    = !valid || (val > cmd.key);
  assign match = valid && (val == cmd.key);

  // Valid bit: grows by one on insert, shrinks by one on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ins) begin
      valid <= valid | left_valid;
    end else if (cmd.pop) begin
      valid <= right_valid;
    end
  end

  // Value: take the key at the insertion point, the left value beyond it
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (gt && !left_gt) begin
        val <= cmd.key;
      end else if (gt) begin
        val <= left_val;
      end
    end else if (cmd.pop) begin
      val <= right_val;
    end
  end

endmodule
`default_nettype wire
